[sv/su2lct_pkg.sv]
`default_nettype none

package su2lct_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int FRAC_BITS = COMPONENT_WIDTH - 2;

  typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
  typedef logic signed [COMPONENT_WIDTH:0] trace_t;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  typedef struct packed {
    comp_t link_w;
    comp_t link_x;
    comp_t link_y;
    comp_t link_z;
    logic  chain_end;
  } link_t;

  typedef struct packed {
    trace_t trace_value;
    comp_t  prod_w;
    comp_t  prod_x;
    comp_t  prod_y;
    comp_t  prod_z;
    logic   saturated;
  } result_t;

  typedef struct packed {
    quat_t prod;
    logic  sat;
  } mul_out_t;

endpackage

`default_nettype wire

[sv/su2lct_mul.sv]
`default_nettype none

module su2lct_mul (
  input  wire su2lct_pkg::quat_t    a,
  input  wire su2lct_pkg::quat_t    b,
  output su2lct_pkg::mul_out_t      res
);

  localparam int CW = su2lct_pkg::COMPONENT_WIDTH;
  localparam int FB = su2lct_pkg::FRAC_BITS;
  localparam int PW = 2 * CW;
  localparam int ACC_W = PW + 3;
  localparam int SH_W = ACC_W - FB;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FB - 1);
  localparam logic signed [SH_W-1:0] C_MAX = SH_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SH_W-1:0] C_MIN = SH_W'(-(64'sd1 <<< (CW - 1)));

  logic signed [PW-1:0] ww, wx, wy, wz;
  logic signed [PW-1:0] xw, xx, xy, xz;
  logic signed [PW-1:0] yw, yx, yy, yz;
  logic signed [PW-1:0] zw, zx, zy, zz;
  logic signed [ACC_W-1:0] sum [4];
  logic signed [ACC_W-1:0] rnd [4];
  logic signed [SH_W-1:0] qv [4];
  su2lct_pkg::comp_t c [4];
  logic [3:0] sat_bits;

  assign ww = a.w * b.w;
  assign wx = a.w * b.x;
  assign wy = a.w * b.y;
  assign wz = a.w * b.z;
  assign xw = a.x * b.w;
  assign xx = a.x * b.x;
  assign xy = a.x * b.y;
  assign xz = a.x * b.z;
  assign yw = a.y * b.w;
  assign yx = a.y * b.x;
  assign yy = a.y * b.y;
  assign yz = a.y * b.z;
  assign zw = a.z * b.w;
  assign zx = a.z * b.x;
  assign zy = a.z * b.y;
  assign zz = a.z * b.z;

  assign sum[0] = ACC_W'(ww) - ACC_W'(xx) - ACC_W'(yy) - ACC_W'(zz);
  assign sum[1] = ACC_W'(wx) + ACC_W'(xw) - ACC_W'(yz) + ACC_W'(zy);
  assign sum[2] = ACC_W'(wy) + ACC_W'(yw) - ACC_W'(zx) + ACC_W'(xz);
  assign sum[3] = ACC_W'(wz) + ACC_W'(zw) - ACC_W'(xy) + ACC_W'(yx);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rnd[k] = sum[k] + HALF;
      qv[k] = $signed(rnd[k][ACC_W-1:FB]);
      if (qv[k] > C_MAX) begin
        c[k] = C_MAX[CW-1:0];
        sat_bits[k] = 1'b1;
      end else if (qv[k] < C_MIN) begin
        c[k] = C_MIN[CW-1:0];
        sat_bits[k] = 1'b1;
      end else begin
        c[k] = qv[k][CW-1:0];
        sat_bits[k] = 1'b0;
      end
    end
  end

  assign res.prod.w = c[0];
  assign res.prod.x = c[1];
  assign res.prod.y = c[2];
  assign res.prod.z = c[3];
  assign res.sat = |sat_bits;

endmodule

`default_nettype wire

[sv/su2_link_chain_trace_core.sv]
// Running product and trace of a chain of SU(2) links in Pauli quaternion form.
// Links enter on the link channel (link_valid, link_ready, link) one item per
// link in path order; chain_end marks the last link of a chain.
// Each link is multiplied onto the running product with rounding to nearest
// and saturation to the Q1.14 component range.
// The link that ends a chain produces one item on the result channel with the
// trace, the four product components and a sticky saturation flag for the chain.
// Other links produce no result.
// The link is captured in an input register at acceptance; the result register loads
// when a chain end advances out of it, so result_valid rises after the chain end has
// passed both registers. One link is accepted in every cycle unless a stalled result
// holds a chain end in the input register. The rate is set by the combinational update
// of the running product by sixteen parallel multipliers and four adder trees.
// When the receiver stalls, the result register holds and links inside a chain
// keep flowing; a chain end that reaches the input register then holds link_ready low.
// Reset clears all valid flags and arms the block for the first link of a chain.

`default_nettype none

module su2_link_chain_trace_core (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       link_valid,
  output logic                      link_ready,
  input  wire su2lct_pkg::link_t    link,
  output logic                      result_valid,
  input  wire                       result_ready,
  output su2lct_pkg::result_t       result
);

  logic s1_valid;
  su2lct_pkg::link_t s1_link;
  su2lct_pkg::quat_t acc;
  logic chain_start;
  logic overflow_seen;

  su2lct_pkg::quat_t b;
  su2lct_pkg::mul_out_t mul_res;
  su2lct_pkg::quat_t prod_next;
  logic overflow_seen_next;
  logic s1_adv;

  assign b.w = s1_link.link_w;
  assign b.x = s1_link.link_x;
  assign b.y = s1_link.link_y;
  assign b.z = s1_link.link_z;

  su2lct_mul u_mul (
    .a   (acc),
    .b   (b),
    .res (mul_res)
  );

  assign prod_next = chain_start ? b : mul_res.prod;
  assign overflow_seen_next = chain_start ? 1'b0 : (overflow_seen | mul_res.sat);
  assign s1_adv = !s1_link.chain_end || !result_valid || result_ready;
  assign link_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (link_ready) begin
      s1_valid <= link_valid;
    end
    if (link_ready && link_valid) begin
      s1_link <= link;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_start <= 1'b1;
      overflow_seen <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      chain_start <= s1_link.chain_end;
      overflow_seen <= overflow_seen_next;
    end
    if (s1_valid && s1_adv) begin
      acc <= prod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_valid && s1_adv && s1_link.chain_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (s1_valid && s1_adv && s1_link.chain_end) begin
      result.trace_value <= $signed({prod_next.w, 1'b0});
      result.prod_w <= prod_next.w;
      result.prod_x <= prod_next.x;
      result.prod_y <= prod_next.y;
      result.prod_z <= prod_next.z;
      result.saturated <= overflow_seen_next;
    end
  end

  a_end_rearms: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && s1_link.chain_end) |=> (chain_start && result_valid))
    else $error("chain end did not rearm the chain or post a result");

  a_mid_link_continues: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && !s1_link.chain_end) |=> !chain_start)
    else $error("link inside a chain restarted the chain");

  a_first_clears_flag: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && chain_start) |=> !overflow_seen)
    else $error("first link of a chain did not clear the saturation flag");

  a_stall_blocks_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready && s1_valid && s1_link.chain_end) |-> !link_ready)
    else $error("input taken while a chain end waits on a stalled result");

endmodule

`default_nettype wire
